/* sv/catalan_number_mod_prime_macros.svh */
// Assertion shorthands shared by the block's modules.
// They expect signals named clk and arst_n in the enclosing module.
`ifndef CATALAN_NUMBER_MOD_PRIME_MACROS_SVH
`define CATALAN_NUMBER_MOD_PRIME_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define CNMP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define CNMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/cnmp_pkg.sv */
package cnmp_pkg;

	localparam int unsigned LEN_W   = 21;
	localparam int unsigned COUNT_W = 30;
	localparam int unsigned M_W     = LEN_W - 1;
	localparam int unsigned CNT_W   = LEN_W;
	localparam int unsigned EXP_W   = 30;
	localparam int unsigned BIT_W   = 5;
	localparam int unsigned STEP_W  = 5;
	localparam int unsigned UROM_DEPTH = 19;

	localparam logic [COUNT_W-1:0] MODP     = 30'd1000000007;
	// Fermat exponent for the inverse
	localparam logic [EXP_W-1:0]   EXP_BITS = MODP - 30'd2;
	// Barrett constant floor(2^60 / P)
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);
	localparam logic [31:0] MODP_X2 = 32'd2000000014;
	localparam logic [31:0] MODP_X3 = 32'd3000000021;

	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [3:0] {
		SRC_N0, SRC_N1, SRC_N2, SRC_D0, SRC_D1, SRC_D2, SRC_ACC,
		SRC_NUMF, SRC_DENF, SRC_ONE
	} src_t;

	typedef enum logic [2:0] {
		REG_N0, REG_N1, REG_N2, REG_D0, REG_D1, REG_D2, REG_ACC
	} reg_t;

	typedef enum logic [2:0] {
		ACT_NONE, ACT_IDLE, ACT_INIT, ACT_STEPC, ACT_STEPB, ACT_OUT, ACT_ZERO
	} act_t;

	typedef enum logic [2:0] {
		JC_NEXT, JC_ALWAYS, JC_BAD, JC_CLOOP, JC_BLOOP
	} jc_t;

	typedef struct packed {
		logic        drain;
		logic        issue;
		logic        on_bit;
		src_t        src_a;
		src_t        src_b;
		reg_t        dst;
		logic [1:0]  off;
		act_t        act;
		jc_t         jc;
		step_t       target;
	} uword_t;

	typedef struct packed {
		logic               valid;
		reg_t               dst;
		logic [COUNT_W-1:0] a;
		logic [COUNT_W-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic               valid;
		reg_t               dst;
		logic [COUNT_W-1:0] value;
	} mul_wb_t;

	localparam step_t ST_IDLE = 5'd0;
	localparam step_t ST_LOOP = 5'd2;
	localparam step_t ST_EXP  = 5'd14;
	localparam step_t ST_ZERO = 5'd18;

	localparam uword_t UW_RESTART =
		'{1'b0, 1'b0, 1'b0, SRC_ONE, SRC_ONE, REG_N0, 2'd0, ACT_NONE, JC_ALWAYS, ST_IDLE};

	localparam uword_t UROM [UROM_DEPTH] = '{
		// 0: wait for a transaction
		'{1'b0, 1'b0, 1'b0, SRC_ONE, SRC_ONE, REG_N0, 2'd0, ACT_IDLE, JC_NEXT, ST_IDLE},
		// 1: set lanes to one, leave for odd or oversized lengths
		'{1'b0, 1'b0, 1'b0, SRC_ONE, SRC_ONE, REG_N0, 2'd0, ACT_INIT, JC_BAD, ST_ZERO},
		// 2..7: six interleaved product lanes
		'{1'b0, 1'b1, 1'b0, SRC_N0, SRC_NUMF, REG_N0, 2'd1, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_D0, SRC_DENF, REG_D0, 2'd1, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_N1, SRC_NUMF, REG_N1, 2'd2, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_D1, SRC_DENF, REG_D1, 2'd2, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_N2, SRC_NUMF, REG_N2, 2'd3, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_D2, SRC_DENF, REG_D2, 2'd3, ACT_STEPC, JC_CLOOP, ST_LOOP},
		// 8..11: fold lanes into numerator N0 and denominator D0
		'{1'b1, 1'b1, 1'b0, SRC_N0, SRC_N1, REG_N0, 2'd0, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_D0, SRC_D1, REG_D0, 2'd0, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b1, 1'b1, 1'b0, SRC_N0, SRC_N2, REG_N0, 2'd0, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_D0, SRC_D2, REG_D0, 2'd0, ACT_NONE, JC_NEXT, ST_IDLE},
		// 12..13: exponent bit 0 is set, start ACC at the base
		'{1'b1, 1'b1, 1'b0, SRC_D0, SRC_ONE, REG_ACC, 2'd0, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_D0, SRC_D0, REG_D0, 2'd0, ACT_NONE, JC_NEXT, ST_IDLE},
		// 14..15: square and multiply over the remaining exponent bits
		'{1'b1, 1'b1, 1'b1, SRC_ACC, SRC_D0, REG_ACC, 2'd0, ACT_NONE, JC_NEXT, ST_IDLE},
		'{1'b0, 1'b1, 1'b0, SRC_D0, SRC_D0, REG_D0, 2'd0, ACT_STEPB, JC_BLOOP, ST_EXP},
		// 16: numerator times inverse
		'{1'b1, 1'b1, 1'b0, SRC_ACC, SRC_N0, REG_ACC, 2'd0, ACT_NONE, JC_NEXT, ST_IDLE},
		// 17: hand out ACC
		'{1'b1, 1'b0, 1'b0, SRC_ONE, SRC_ONE, REG_N0, 2'd0, ACT_OUT, JC_ALWAYS, ST_IDLE},
		// 18: hand out zero
		'{1'b0, 1'b0, 1'b0, SRC_ONE, SRC_ONE, REG_N0, 2'd0, ACT_ZERO, JC_ALWAYS, ST_IDLE}
	};

endpackage

/* sv/cnmp_mulmod.sv */
`include "catalan_number_mod_prime_macros.svh"

module cnmp_mulmod (
	input  logic              clk,
	input  logic              arst_n,
	input  cnmp_pkg::mul_req_t req,
	output cnmp_pkg::mul_wb_t  wb,
	output logic              busy
);
	import cnmp_pkg::*;

	logic        vld_s1, vld_s2, vld_s3, vld_s4;
	reg_t        dst_s1, dst_s2, dst_s3, dst_s4;
	logic [59:0] x_s1;
	logic [61:0] q2_s2;
	logic [31:0] xlo_s2, xlo_s3;
	logic [31:0] q3p_s3;
	logic [31:0] r_s4;
	logic [31:0] r_m1, r_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		dst_s1 <= req.dst;
		x_s1   <= 60'(req.a) * 60'(req.b);
		dst_s2 <= dst_s1;
		q2_s2  <= 62'(x_s1[59:29]) * 62'(BARRETT_MU);
		xlo_s2 <= x_s1[31:0];
		dst_s3 <= dst_s2;
		q3p_s3 <= 32'(q2_s2[61:31]) * 32'(MODP);
		xlo_s3 <= xlo_s2;
		dst_s4 <= dst_s3;
		r_s4   <= xlo_s3 - q3p_s3;
	end

	// Barrett leaves the remainder below 3P: drop P or 2P
	assign r_m1 = r_s4 - 32'(MODP);
	assign r_m2 = r_s4 - MODP_X2;

	always_comb begin
		wb.valid = vld_s4;
		wb.dst   = dst_s4;
		if (r_s4 >= MODP_X2) begin
			wb.value = r_m2[COUNT_W-1:0];
		end else if (r_s4 >= 32'(MODP)) begin
			wb.value = r_m1[COUNT_W-1:0];
		end else begin
			wb.value = r_s4[COUNT_W-1:0];
		end
	end

	assign busy = vld_s1 | vld_s2 | vld_s3 | vld_s4;

	`CNMP_ASSERT_IMP(a_barrett_bound, vld_s4, r_s4 < MODP_X3, "remainder not below 3P")

endmodule

/* sv/cnmp_urom.sv */
module cnmp_urom (
	input  cnmp_pkg::step_t  step,
	output cnmp_pkg::uword_t word
);
	import cnmp_pkg::*;

	always_comb begin
		if (step < STEP_W'(UROM_DEPTH)) begin
			word = UROM[step];
		end else begin
			word = UW_RESTART;
		end
	end

endmodule

/* sv/catalan_number_mod_prime.sv */
// Odd or oversized length: the init step jumps to the zero step, which loads zero as the result;
// even length: factor loop, lane folding, Fermat inverse and final multiply, then the result loads.
// One transaction at a time: the next one is taken back at the idle step after the result loads;
// the factor loop issues one modular multiply per cycle into a 4-stage Barrett pipeline,
// and the Fermat inverse waits for that pipeline to drain before each exponent-bit step.
// The next transaction is taken while a finished result still waits on the master side.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and empties the output.
`include "catalan_number_mod_prime_macros.svh"

module catalan_number_mod_prime #(
	parameter int unsigned MAX_LENGTH = 1048576
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [20:0] length
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [29:0] count
);
	import cnmp_pkg::*;

	// Sequencer state
	step_t            step_q;
	uword_t           w;
	logic [LEN_W-1:0] length_q;
	logic [CNT_W-1:0] c_q;
	logic [BIT_W-1:0] b_q;

	// Datapath registers: three numerator lanes, three denominator lanes, accumulator
	logic [COUNT_W-1:0] n0_q, n1_q, n2_q, d0_q, d1_q, d2_q, acc_q;

	// Output register
	logic               m_tvalid_q;
	logic [COUNT_W-1:0] count_q;

	logic [M_W-1:0]     m;
	logic               bad;
	logic [CNT_W-1:0]   s_sum;
	logic [COUNT_W-1:0] numf, denf;
	logic [COUNT_W-1:0] opa, opb;
	logic               accept, out_slot, go, take_jump, load_out;
	mul_req_t           mul_req;
	mul_wb_t            wb;
	logic               busy;

	cnmp_urom u_urom (
		.step (step_q),
		.word (w)
	);

	cnmp_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.wb     (wb),
		.busy   (busy)
	);

	assign m   = length_q[LEN_W-1:1];
	assign bad = length_q[0] | (32'(length_q) > MAX_LENGTH);

	// Factor for this slot: numerator runs m+1..2m, denominator 1..m+1, pad with one
	assign s_sum = c_q + CNT_W'(w.off);
	always_comb begin
		if (s_sum <= CNT_W'(m)) begin
			numf = COUNT_W'(m) + COUNT_W'(s_sum);
		end else begin
			numf = COUNT_W'(1);
		end
		if (s_sum <= CNT_W'(m) + CNT_W'(1)) begin
			denf = COUNT_W'(s_sum);
		end else begin
			denf = COUNT_W'(1);
		end
	end

	// Operand select
	always_comb begin
		case (w.src_a)
			SRC_N0:   opa = n0_q;
			SRC_N1:   opa = n1_q;
			SRC_N2:   opa = n2_q;
			SRC_D0:   opa = d0_q;
			SRC_D1:   opa = d1_q;
			SRC_D2:   opa = d2_q;
			SRC_ACC:  opa = acc_q;
			SRC_NUMF: opa = numf;
			SRC_DENF: opa = denf;
			default:  opa = COUNT_W'(1);
		endcase
		case (w.src_b)
			SRC_N0:   opb = n0_q;
			SRC_N1:   opb = n1_q;
			SRC_N2:   opb = n2_q;
			SRC_D0:   opb = d0_q;
			SRC_D1:   opb = d1_q;
			SRC_D2:   opb = d2_q;
			SRC_ACC:  opb = acc_q;
			SRC_NUMF: opb = numf;
			SRC_DENF: opb = denf;
			default:  opb = COUNT_W'(1);
		endcase
	end

	// Step control: hold on an empty input, a full output, or a pending writeback
	assign s_tready = (w.act == ACT_IDLE);
	assign accept   = s_tvalid & s_tready;
	assign out_slot = !m_tvalid_q || m_tready;

	always_comb begin
		go = 1'b1;
		if (w.drain && busy) begin
			go = 1'b0;
		end
		if (w.act == ACT_IDLE && !s_tvalid) begin
			go = 1'b0;
		end
		if ((w.act == ACT_OUT || w.act == ACT_ZERO) && !out_slot) begin
			go = 1'b0;
		end
	end

	always_comb begin
		case (w.jc)
			JC_NEXT:   take_jump = 1'b0;
			JC_ALWAYS: take_jump = 1'b1;
			JC_BAD:    take_jump = bad;
			JC_CLOOP:  take_jump = (c_q + CNT_W'(3)) <= CNT_W'(m);
			JC_BLOOP:  take_jump = b_q < BIT_W'(EXP_W - 1);
			default:   take_jump = 1'b0;
		endcase
	end

	// Multiply issue; a square-and-multiply step skips clear exponent bits
	always_comb begin
		mul_req.valid = go && w.issue && (!w.on_bit || EXP_BITS[b_q]);
		mul_req.dst   = w.dst;
		mul_req.a     = opa;
		mul_req.b     = opb;
	end

	assign load_out = go && (w.act == ACT_OUT || w.act == ACT_ZERO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= ST_IDLE;
			c_q        <= '0;
			b_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (go) begin
				if (take_jump) begin
					step_q <= w.target;
				end else begin
					step_q <= step_q + step_t'(1);
				end
				case (w.act)
					ACT_INIT: begin
						c_q <= '0;
						b_q <= BIT_W'(1);
					end
					ACT_STEPC: c_q <= c_q + CNT_W'(3);
					ACT_STEPB: b_q <= b_q + BIT_W'(1);
					default: ;
				endcase
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Capture the transaction and the result
	always_ff @(posedge clk) begin
		if (accept) begin
			length_q <= s_tdata[LEN_W-1:0];
		end
		if (load_out) begin
			count_q <= (w.act == ACT_OUT) ? acc_q : '0;
		end
	end

	// Lane setup and writeback; the pipe is always empty when lanes are set up
	always_ff @(posedge clk) begin
		if (go && w.act == ACT_INIT) begin
			n0_q <= COUNT_W'(1);
			n1_q <= COUNT_W'(1);
			n2_q <= COUNT_W'(1);
			d0_q <= COUNT_W'(1);
			d1_q <= COUNT_W'(1);
			d2_q <= COUNT_W'(1);
		end else if (wb.valid) begin
			case (wb.dst)
				REG_N0:  n0_q  <= wb.value;
				REG_N1:  n1_q  <= wb.value;
				REG_N2:  n2_q  <= wb.value;
				REG_D0:  d0_q  <= wb.value;
				REG_D1:  d1_q  <= wb.value;
				REG_D2:  d2_q  <= wb.value;
				REG_ACC: acc_q <= wb.value;
				default: ;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, count_q};

	`CNMP_ASSERT_IMP(a_idle_pipe_empty, w.act == ACT_IDLE, !busy, "multiply in flight while idle")
	`CNMP_ASSERT_IMP(a_out_drained, load_out, !busy, "result taken before last writeback")
	`CNMP_ASSERT_IMP(a_count_reduced, m_tvalid_q, count_q < MODP, "count not reduced mod P")
	`CNMP_ASSERT_NEXT(a_issue_busy, mul_req.valid, busy, "issued multiply not in pipe")

endmodule

/* bench/catalan_number_mod_prime_tb.sv */
`timescale 1ns / 100ps

module catalan_number_mod_prime_tb;

	localparam int unsigned       LEN_BITS   = 21;
	localparam int unsigned       COUNT_BITS = 30;
	localparam int unsigned       MAX_LEN    = 1048576;
	localparam longint unsigned   PRIME      = 64'd1000000007;

	// Random queries after the directed ones.
	localparam int                RANDOM_ITEMS = 100;
	// Receiver hold-off: starts once this many results are in; HOLD_CYCLES sets how long it lasts.
	localparam int                HOLD_AT      = 28;
	localparam int                HOLD_CYCLES  = 4000;
	// Results in this window are taken with no back-pressure at all.
	localparam int                STEADY_FROM  = 40;
	localparam int                STEADY_TO    = 65;
	// One full-size query costs more than all the rest together.
	localparam longint            RUN_LIMIT_NS = 80_000_000;

	typedef struct {
		logic [LEN_BITS-1:0] len;
		bit                  steady;      // offer without random gaps
		bit                  drain_first; // hold off until every count is back
	} query_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;   // [20:0] length
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;         // [29:0] count

	query_t                pending[$];
	logic [COUNT_BITS-1:0] count_q[$];   // expected counts, oldest first
	logic                  in_fire   = 1'b0;
	int                    got       = 0;
	int                    fail_count = 0;
	int                    hold_left = 0;
	bit                    hold_done = 1'b0;

	catalan_number_mod_prime #(
		.MAX_LENGTH(MAX_LEN)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Balanced bracket count for a length, mod the prime: (2m)! / (m! (m+1)!).
	// Odd lengths and lengths past the served range count as zero.
	function automatic logic [COUNT_BITS-1:0] catalan_mod(logic [LEN_BITS-1:0] len);
		longint unsigned half, fact, fact_m, fact_m1, base, ex, inv;
		if (len[0] || len > MAX_LEN)
			return '0;
		half    = len >> 1;
		fact    = 1;
		fact_m  = 1;
		fact_m1 = 1;
		for (longint unsigned k = 1; k <= len; k++) begin
			fact = (fact * k) % PRIME;
			if (k == half)
				fact_m = fact;
			if (k == half + 1)
				fact_m1 = fact;
		end
		// Invert m! (m+1)! by raising it to P-2.
		base = (fact_m * fact_m1) % PRIME;
		ex   = PRIME - 2;
		inv  = 1;
		while (ex != 0) begin
			if (ex[0])
				inv = (inv * base) % PRIME;
			base = (base * base) % PRIME;
			ex   = ex >> 1;
		end
		return COUNT_BITS'((fact * inv) % PRIME);
	endfunction

	task automatic add_query(logic [LEN_BITS-1:0] len, bit steady, bit drain_first);
		query_t q;
		q.len         = len;
		q.steady      = steady;
		q.drain_first = drain_first;
		pending.push_back(q);
	endtask

	// Sender: change s_tvalid/s_tdata only on the falling edge. Hold the current
	// transaction until the rising edge that takes it, then pick the next one or idle.
	always @(negedge clk) begin
		query_t q;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (pending.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				q = pending[0];
				if (q.drain_first && count_q.size() != 0) begin
					// pause until the block has handed back everything
					s_tvalid <= 1'b0;
				end else if (!q.steady && $urandom_range(99) < 26) begin
					s_tvalid <= 1'b0;
					s_tdata  <= {3'b000, LEN_BITS'($urandom)};
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= {3'b000, q.len};
					void'(pending.pop_front());
				end
			end
		end
	end

	// Receiver: drive m_tready on the falling edge. One long hold-off fills the block
	// up so it has to stall its input; a window of results goes through with no stall.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && got == HOLD_AT) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (got >= STEADY_FROM && got < STEADY_TO) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 26);
		end
	end

	// Sample both sides on the rising edge: check the result against the oldest
	// expected count first, then queue the expectation for a newly taken length.
	always @(posedge clk) begin
		logic [COUNT_BITS-1:0] want;
		if (arst_n) begin
			in_fire <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got <= got + 1;
				if (count_q.size() == 0) begin
					$error("count: expected none, actual %0d", m_tdata[COUNT_BITS-1:0]);
					fail_count++;
				end else begin
					want = count_q.pop_front();
					if (m_tdata[COUNT_BITS-1:0] !== want) begin
						$error("count: expected %0d, actual %0d", want,
							m_tdata[COUNT_BITS-1:0]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				count_q.push_back(catalan_mod(s_tdata[LEN_BITS-1:0]));
		end
	end

	initial begin
		// Empty sequence, smallest even and odd lengths, the top of the served
		// range and just past it, and all-ones / odd / even lengths out of range.
		int unsigned directed_len [18] = '{
			0, 1, 2, 3, 4, 6, 8, 10, 100, 1000, 999,
			1048575, 1048576, 1048577, 1048578, 1398102, 2097150, 2097151
		};
		int unsigned          pick;
		logic [LEN_BITS-1:0]  len;

		foreach (directed_len[i])
			add_query(LEN_BITS'(directed_len[i]), 1'b0, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(99);
			if (i >= 12 && i < 26) begin
				// tiny queries around the receiver hold-off so the block backs up
				len = LEN_BITS'($urandom_range(40));
			end else if (pick < 50) begin
				len = LEN_BITS'(2 * $urandom_range(40));
			end else if (pick < 70) begin
				len = LEN_BITS'(2 * $urandom_range(1000));
			end else if (pick < 85) begin
				len = LEN_BITS'($urandom) | LEN_BITS'(1);
			end else begin
				len = LEN_BITS'($urandom_range(2 ** LEN_BITS - 1, MAX_LEN + 1));
			end
			add_query(len, (i >= 32 && i < 58), (i == 5));
		end

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// Let the sender run dry, then wait for every count to come back.
		while (pending.size() != 0 || s_tvalid || count_q.size() != 0)
			@(posedge clk);
		// Catch any stray result after the last expected one.
		repeat (300) @(posedge clk);

		if (fail_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("end of test: mismatches");
		$finish;
	end

endmodule
